// ===== design/odwd_pkg.sv =====
// Shared constants, codes and types of the ordered deque with delete.
package odwd_pkg;

   // Sizes of the list and of the item fields.
   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int INDEX_W  = $clog2(CAPACITY);

   // Packing of the request and response data words.
   localparam int REQ_W    = ((KIND_W + VALUE_W + 7) / 8) * 8;
   localparam int KIND_LO  = 0;
   localparam int VALUE_LO = KIND_LO + KIND_W;
   localparam int RSP_BITS = STATUS_W + COUNT_W + 2 * VALUE_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int STATUS_LO = 0;
   localparam int COUNT_LO  = STATUS_LO + STATUS_W;
   localparam int FIRST_LO  = COUNT_LO + COUNT_W;
   localparam int LAST_LO   = FIRST_LO + VALUE_W;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation codes carried in the kind field.
   typedef enum logic [KIND_W-1:0] {
      KIND_FRONT  = 2'd0,
      KIND_BACK   = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // Status codes returned with each result.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // States of the back engine.
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_APPLY,
      BACK_REPORT
   } back_state_type;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  value;
   } odwd_item_type;

endpackage

// ===== design/odwd_front.sv =====
// Front part: accepts request items, classifies them and queues them for the back.
module odwd_front import odwd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,
   output logic                item_valid,
   input  logic                item_ready,
   output odwd_item_type       item
);

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   odwd_item_type     slot_ff [QUEUE_DEPTH];
   odwd_item_type     slot_in;
   logic              push;
   logic              pop;

   // Decode the incoming item into its operation and value.
   always_comb begin
      slot_in.kind  = kind_type'(req_tdata[KIND_LO +: KIND_W]);
      slot_in.value = req_tdata[VALUE_LO +: VALUE_W];
   end

   // Handshakes on both sides of the queue.
   assign req_tready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (fill_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Queue control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage; payload only, so no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

// ===== design/odwd_back.sv =====
// Back part: holds the entry cells, carries out each operation and registers the result.
module odwd_back import odwd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  odwd_item_type       item,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata
);

   back_state_type             state_ff, state_in;
   logic [VALUE_W-1:0]         cells_ff [CAPACITY];
   logic [VALUE_W-1:0]         cells_in [CAPACITY];
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [CAPACITY-1:0]        match_ff, match_in;
   kind_type                   kind_ff;
   logic [VALUE_W-1:0]         value_ff;
   status_type                 status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                       take_item;
   logic                       do_apply;
   logic                       do_report;
   logic                       out_free;
   logic                       is_full;
   logic                       is_empty;
   logic [CAPACITY-1:0]        first_hit;
   logic [CAPACITY-1:0]        shift_mask;
   logic [INDEX_W-1:0]         last_idx;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state of the operation sequence.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE:   if (item_valid) state_in = BACK_APPLY;
         BACK_APPLY:  state_in = BACK_REPORT;
         BACK_REPORT: if (out_free) state_in = BACK_IDLE;
         default:     state_in = BACK_IDLE;
      endcase
   end

   // Control outputs of the operation sequence.
   always_comb begin
      take_item = 1'b0;
      do_apply  = 1'b0;
      do_report = 1'b0;
      case (state_ff)
         BACK_IDLE:   take_item = 1'b1;
         BACK_APPLY:  do_apply  = 1'b1;
         BACK_REPORT: do_report = out_free;
         default:     take_item = 1'b0;
      endcase
   end

   assign item_ready = take_item;

   // Compare every live cell with the incoming value in parallel.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (COUNT_W'(i) < count_ff) && (cells_ff[i] == item.value);
      end
   end

   // The first match from the front and every cell from it onwards.
   assign first_hit  = match_ff & (~match_ff + 1'b1);
   assign shift_mask = ~(first_hit - 1'b1);
   assign is_full    = (count_ff == COUNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   // New cell contents, count and status for the latched operation.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
      end
      count_in  = count_ff;
      status_in = ST_DONE;
      case (kind_ff)
         KIND_FRONT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               cells_in[0] = value_ff;
               for (int i = 1; i < CAPACITY; i++) begin
                  cells_in[i] = cells_ff[i-1];
               end
               count_in = count_ff + 1'b1;
            end
         end
         KIND_BACK: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (COUNT_W'(i) == count_ff) cells_in[i] = value_ff;
               end
               count_in = count_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else if (match_ff == '0) begin
               status_in = ST_NOT_FOUND;
            end else begin
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (shift_mask[i]) cells_in[i] = cells_ff[i+1];
               end
               count_in = count_ff - 1'b1;
            end
         end
         default: status_in = ST_DONE;
      endcase
   end

   // Pack the result from the updated cells.
   assign last_idx = INDEX_W'(count_ff - 1'b1);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[STATUS_LO +: STATUS_W] = status_ff;
      rsp_data_in[COUNT_LO +: COUNT_W]   = count_ff;
      rsp_data_in[FIRST_LO +: VALUE_W]   = is_empty ? '0 : cells_ff[0];
      rsp_data_in[LAST_LO +: VALUE_W]    = is_empty ? '0 : cells_ff[last_idx];
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_apply) count_ff <= count_in;
      end
   end

   // Payload registers: latched item, match vector, cells, status and result.
   always_ff @(posedge clock) begin
      if (take_item && item_valid) begin
         kind_ff  <= item.kind;
         value_ff <= item.value;
         match_ff <= match_in;
      end
      if (do_apply) begin
         cells_ff  <= cells_in;
         status_ff <= status_in;
      end
      if (do_report) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/ordered_deque_with_delete.sv =====
// Ordered deque with delete-by-value, top level joining the front queue and the back engine.
// The block holds up to CAPACITY signed 32-bit entries in order. Each request item inserts its
// value at the front, appends it at the back, or removes the first entry from the front that
// equals it, closing up the gap; kind 3 changes nothing. Every item gives exactly one response
// item with a status, the entry count and the first and last values (zero when empty). The
// back engine takes each item through a parallel compare, a cell update and a result load, and
// takes no new item until it has loaded the result of the last; the two-deep queue in front
// accepts items, until it is full, while the engine or the response register is busy.
module ordered_deque_with_delete import odwd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // kind [1:0], value [33:2], zero pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata    // status, entry_count, first_value, last_value
);

   logic          item_valid;
   logic          item_ready;
   odwd_item_type item;

   // Accept and classify request items.
   odwd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // Carry out operations and return results.
   odwd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/odwd_checker.sv =====
// Port checker of the ordered deque with delete, bound to the top level.
module odwd_checker import odwd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_W-1:0]    rsp_tdata
);

   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;
   logic [VALUE_W-1:0]  rsp_first;
   logic [VALUE_W-1:0]  rsp_last;

   // Unpack the response fields.
   assign rsp_status = rsp_tdata[STATUS_LO +: STATUS_W];
   assign rsp_count  = rsp_tdata[COUNT_LO +: COUNT_W];
   assign rsp_first  = rsp_tdata[FIRST_LO +: VALUE_W];
   assign rsp_last   = rsp_tdata[LAST_LO +: VALUE_W];

   // A stalled response item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response item changed while stalled");

   // The count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // An empty list reports zero first and last values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_count == '0 |-> rsp_first == '0 && rsp_last == '0)
      else $error("empty list reported non-zero values");

   // A rejected insert happens only on a full list.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(CAPACITY))
      else $error("full status with list not full");

   // A remove on an empty list leaves it empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_EMPTY |-> rsp_count == '0)
      else $error("empty status with entries held");

endmodule

bind ordered_deque_with_delete odwd_checker u_checker (.*);
